FILE: design/zrb_pkg.sv
// Shared constants, register codes and control/status types of the zigzag reorder buffer.
`timescale 1ns / 1ps
`default_nettype none

package zrb_pkg;

   // Matrix limits and word size.
   localparam int DATA_WIDTH  = 32;
   localparam int MAX_ROWS    = 8;
   localparam int MAX_COLS    = 8;
   localparam int STORE_DEPTH = MAX_ROWS * MAX_COLS;

   // Derived widths.
   localparam int ADDR_WIDTH  = $clog2(STORE_DEPTH);
   localparam int COUNT_WIDTH = ADDR_WIDTH + 1;
   localparam int ROW_WIDTH   = 3;
   localparam int COL_WIDTH   = 3;
   localparam int DIM_WIDTH   = 4;

   // Result word: value, row, column, padded to whole bytes.
   localparam int RSP_FIELDS_WIDTH = DATA_WIDTH + ROW_WIDTH + COL_WIDTH;
   localparam int RSP_TDATA_WIDTH  = ((RSP_FIELDS_WIDTH + 7) / 8) * 8;
   localparam int RSP_PAD_WIDTH    = RSP_TDATA_WIDTH - RSP_FIELDS_WIDTH;
   localparam int REQ_TDATA_WIDTH  = ((DATA_WIDTH + 7) / 8) * 8;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_ROWS = 2'd0,
      REG_COLS = 2'd1
   } csr_reg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic wr_en;       // store the accepted item and advance the load count
      logic walk_clear;  // load complete: clear count, restart walk at top-left
      logic rd_en;       // read the store at the current walk position
      logic push;        // load the output register and step the walk
   } zrb_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic load_done;   // the item being stored completes the matrix
      logic walk_fin;    // walk sits on the bottom-right element
      logic out_free;    // output register can take a new item
   } zrb_status_type;

endpackage : zrb_pkg

`default_nettype wire

FILE: design/zrb_ctrl.sv
// Controller state machine: loading, store read and result hand-off sequencing.
`timescale 1ns / 1ps
`default_nettype none

module zrb_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire zrb_pkg::zrb_status_type status,
   output zrb_pkg::zrb_cmd_type        cmd
);
   import zrb_pkg::*;

   typedef enum logic [1:0] {
      S_LOAD,
      S_READ,
      S_PUSH
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   // Items enter only while loading and out of reset.
   assign req_tready = (state_ff == S_LOAD) && !reset;
   assign accept     = req_tvalid && req_tready;

   // Command decode and next state.
   always_comb begin
      cmd        = '0;
      state_in   = state_ff;
      case (state_ff)
         S_LOAD: begin
            cmd.wr_en      = accept;
            cmd.walk_clear = accept && status.load_done;
            if (accept && status.load_done) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = S_PUSH;
         end
         S_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               state_in = status.walk_fin ? S_LOAD : S_READ;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule : zrb_ctrl

`default_nettype wire

FILE: design/zrb_datapath.sv
// Datapath: size registers, element store, load counter, zigzag walker and output register.
`timescale 1ns / 1ps
`default_nettype none

module zrb_datapath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // Configuration writes.
   input  wire logic                                   csr_valid,
   input  wire logic [zrb_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [zrb_pkg::DIM_WIDTH-1:0]          csr_wdata,
   // Input item payload.
   input  wire logic [zrb_pkg::DATA_WIDTH-1:0]         element,
   // Controller link.
   input  wire zrb_pkg::zrb_cmd_type                   cmd,
   output zrb_pkg::zrb_status_type                     status,
   // Result register.
   output logic                                        rsp_tvalid,
   input  wire logic                                   rsp_tready,
   output logic [zrb_pkg::DATA_WIDTH-1:0]              out_value,
   output logic [zrb_pkg::ROW_WIDTH-1:0]               out_row,
   output logic [zrb_pkg::COL_WIDTH-1:0]               out_col,
   output logic                                        out_last
);
   import zrb_pkg::*;

   // Zero counts as one, anything above the limit saturates.
   function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [DIM_WIDTH-1:0] v,
                                                       input logic [DIM_WIDTH-1:0] maxv);
      logic [DIM_WIDTH-1:0] res;
      if (v == '0) begin
         res = DIM_WIDTH'(1);
      end else if (v > maxv) begin
         res = maxv;
      end else begin
         res = v;
      end
      return res;
   endfunction

   logic [DIM_WIDTH-1:0]   rows_ff;
   logic [DIM_WIDTH-1:0]   cols_ff;
   logic [DIM_WIDTH-1:0]   nr;
   logic [DIM_WIDTH-1:0]   nc;
   logic [ROW_WIDTH-1:0]   nr_last;
   logic [COL_WIDTH-1:0]   nc_last;
   logic [COUNT_WIDTH-1:0] total;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_inc;

   logic [DATA_WIDTH-1:0]  store_ff [STORE_DEPTH];
   logic [DATA_WIDTH-1:0]  rd_data_ff;
   logic [COUNT_WIDTH-1:0] addr_full;
   logic [ADDR_WIDTH-1:0]  rd_addr;

   logic [ROW_WIDTH-1:0]   r_ff;
   logic [COL_WIDTH-1:0]   c_ff;
   logic                   up_ff;
   logic [ROW_WIDTH-1:0]   r_in;
   logic [COL_WIDTH-1:0]   c_in;
   logic                   up_in;
   logic                   fin;

   logic                   valid_ff;
   logic                   out_free;

   // Size registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff <= DIM_WIDTH'(MAX_ROWS);
         cols_ff <= DIM_WIDTH'(MAX_COLS);
      end else if (csr_valid) begin
         if (csr_index == REG_ROWS) begin
            rows_ff <= csr_wdata;
         end else if (csr_index == REG_COLS) begin
            cols_ff <= csr_wdata;
         end
      end
   end

   // Effective sizes and element total.
   assign nr        = clamp_dim(rows_ff, DIM_WIDTH'(MAX_ROWS));
   assign nc        = clamp_dim(cols_ff, DIM_WIDTH'(MAX_COLS));
   assign nr_last   = ROW_WIDTH'(nr - DIM_WIDTH'(1));
   assign nc_last   = COL_WIDTH'(nc - DIM_WIDTH'(1));
   assign total     = COUNT_WIDTH'(nr) * COUNT_WIDTH'(nc);
   assign count_inc = count_ff + COUNT_WIDTH'(1);

   // Load counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.walk_clear) begin
         count_ff <= '0;
      end else if (cmd.wr_en) begin
         count_ff <= count_inc;
      end
   end

   // Element store: written in load order, read with a registered port.
   assign addr_full = COUNT_WIDTH'(r_ff) * COUNT_WIDTH'(nc) + COUNT_WIDTH'(c_ff);
   assign rd_addr   = addr_full[ADDR_WIDTH-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         store_ff[count_ff[ADDR_WIDTH-1:0]] <= element;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   // Next zigzag position.
   assign fin = (r_ff == nr_last) && (c_ff == nc_last);

   always_comb begin
      r_in  = r_ff;
      c_in  = c_ff;
      up_in = up_ff;
      if (up_ff) begin
         if (r_ff == '0 && c_ff < nc_last) begin
            c_in  = c_ff + COL_WIDTH'(1);
            up_in = 1'b0;
         end else if (c_ff == nc_last) begin
            r_in  = r_ff + ROW_WIDTH'(1);
            up_in = 1'b0;
         end else begin
            r_in = r_ff - ROW_WIDTH'(1);
            c_in = c_ff + COL_WIDTH'(1);
         end
      end else begin
         if (c_ff == '0 && r_ff < nr_last) begin
            r_in  = r_ff + ROW_WIDTH'(1);
            up_in = 1'b1;
         end else if (r_ff == nr_last) begin
            c_in  = c_ff + COL_WIDTH'(1);
            up_in = 1'b1;
         end else begin
            r_in = r_ff + ROW_WIDTH'(1);
            c_in = c_ff - COL_WIDTH'(1);
         end
      end
   end

   // Walk position.
   always_ff @(posedge clock) begin
      if (reset || cmd.walk_clear) begin
         r_ff  <= '0;
         c_ff  <= '0;
         up_ff <= 1'b1;
      end else if (cmd.push) begin
         r_ff  <= r_in;
         c_ff  <= c_in;
         up_ff <= up_in;
      end
   end

   // Output register.
   assign out_free = !valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (cmd.push) begin
         valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         out_value <= rd_data_ff;
         out_row   <= r_ff;
         out_col   <= c_ff;
         out_last  <= fin;
      end
   end

   assign rsp_tvalid       = valid_ff;
   assign status.load_done = (count_inc >= total);
   assign status.walk_fin  = fin;
   assign status.out_free  = out_free;

   // The load count is idle at zero while the matrix is read out.
   a_count_idle_on_read: assert property (@(posedge clock) disable iff (reset)
      cmd.rd_en |-> (count_ff == '0))
      else $error("load count not cleared during readout");

   // A result is only pushed when the output register can take it.
   a_push_free: assert property (@(posedge clock) disable iff (reset)
      cmd.push |-> out_free)
      else $error("result pushed over a waiting item");

   // The load count never reaches the store depth.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff < COUNT_WIDTH'(STORE_DEPTH))
      else $error("load count out of range");

   // Pushing the final element leaves it waiting in the output register, flagged as last.
   a_last_once: assert property (@(posedge clock) disable iff (reset)
      (cmd.push && fin) |=> (valid_ff && out_last))
      else $error("final item lost after push");

endmodule : zrb_datapath

`default_nettype wire

FILE: design/zigzag_reorder_buffer_top.sv
// Top level of the zigzag reorder buffer: controller and datapath with stream ports.
//
//   Channel   Direction  Handshake              Payload
//   req_      in         req_tvalid/req_tready  tdata[31:0] element
//   rsp_      out        rsp_tvalid/rsp_tready  tdata value,row,col; tlast last
//   csr_      in         csr_valid/csr_ready    csr_index, csr_wdata
//
// Items are stored in load order; the item that completes the matrix starts readout.
// Readout handles each result in two steps, a registered store read and then the output load, before the next read.
// No items are taken during readout; a waiting result stalls the walk.
// Reset clears the load count and sets both sizes to 8; store contents are not cleared.
// Configuration writes are taken whenever reset is low.
`timescale 1ns / 1ps
`default_nettype none

module zigzag_reorder_buffer_top (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // Input items.
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [zrb_pkg::REQ_TDATA_WIDTH-1:0]   req_tdata,  // [31:0] element
   // Result items.
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   output logic [zrb_pkg::RSP_TDATA_WIDTH-1:0]        rsp_tdata,  // [31:0] out_value,
                                                                  // [34:32] out_row,
                                                                  // [37:35] out_col, rest 0
   output logic                                       rsp_tlast,  // out_last
   // Configuration writes.
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [zrb_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [zrb_pkg::DIM_WIDTH-1:0]         csr_wdata
);
   import zrb_pkg::*;

   zrb_cmd_type           cmd;
   zrb_status_type        status;
   logic [DATA_WIDTH-1:0] out_value;
   logic [ROW_WIDTH-1:0]  out_row;
   logic [COL_WIDTH-1:0]  out_col;

   assign csr_ready = !reset;

   // Sequencing.
   zrb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Storage, walk and output register.
   zrb_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .element    (req_tdata[DATA_WIDTH-1:0]),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .out_value  (out_value),
      .out_row    (out_row),
      .out_col    (out_col),
      .out_last   (rsp_tlast)
   );

   // Result packing.
   assign rsp_tdata = {{RSP_PAD_WIDTH{1'b0}}, out_col, out_row, out_value};

endmodule : zigzag_reorder_buffer_top

`default_nettype wire

FILE: tb/tb_zigzag_reorder_buffer_top.sv
// Self-checking testbench for the zigzag reorder buffer: directed table, random loads, checking.
`timescale 1ns / 1ps

module tb_zigzag_reorder_buffer_top;
   import zrb_pkg::*;

   localparam int RANDOM_ITEMS    = 500;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 6;
   localparam int RUN_LIMIT_NS    = 600_000;

   // One result item of the zigzag readout.
   typedef struct packed {
      logic [DATA_WIDTH-1:0] value;
      logic [ROW_WIDTH-1:0]  row;
      logic [COL_WIDTH-1:0]  col;
      logic                  last;
   } readout_type;

   // Rows of the directed table: a size setting, or an element with or without a typed result.
   typedef enum logic [1:0] {
      STEP_SET_DIMS,
      STEP_LOAD,
      STEP_LOAD_TYPED
   } step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [DIM_WIDTH-1:0]  rows;
      logic [DIM_WIDTH-1:0]  cols;
      logic [DATA_WIDTH-1:0] element;
      readout_type           typed;
   } directed_step_type;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   localparam int PLAN_LEN = 29;

   // Clock and reset.
   logic clock = 1'b0;
   logic reset = 1'b1;

   always #1 clock = ~clock;

   // Block ports.
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = REG_ROWS;
   logic [DIM_WIDTH-1:0]       csr_wdata = '0;

   zigzag_reorder_buffer_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // Shadow copy of the block: sizes, element store and load count.
   logic [DIM_WIDTH-1:0]  cfg_rows = 4'd8;
   logic [DIM_WIDTH-1:0]  cfg_cols = 4'd8;
   logic [DATA_WIDTH-1:0] element_mem [STORE_DEPTH];
   int                    load_count = 0;

   // Walk of the matrix just completed, and readout items still owed by the block.
   readout_type walk_order [$];
   readout_type readout_queue [$];

   int error_count     = 0;
   int elements_loaded = 0;
   int matrices_read   = 0;
   int results_checked = 0;
   int dim_settings    = 0;
   int sender_gap_pct  = 0;
   int receiver_stall_pct = 0;
   int hold_off_reqs   = 0;
   int hold_off_seen   = 0;
   int hold_left       = 0;

   directed_step_type plan [0:PLAN_LEN-1];

   // A size register of zero means one; values above the maximum saturate.
   function automatic int span_of(input logic [DIM_WIDTH-1:0] v, input int maxv);
      if (v == 0) return 1;
      if (int'(v) > maxv) return maxv;
      return int'(v);
   endfunction

   // Stores one element; when the matrix is complete, lays out its zigzag readout.
   function automatic void load_element(input logic [DATA_WIDTH-1:0] value);
      int          nr;
      int          nc;
      int          total;
      int          r;
      int          c;
      bit          up;
      bit          fin;
      readout_type entry;
      nr    = span_of(cfg_rows, MAX_ROWS);
      nc    = span_of(cfg_cols, MAX_COLS);
      total = nr * nc;
      element_mem[load_count] = value;
      load_count++;
      elements_loaded++;
      if (load_count < total) return;
      load_count = 0;
      matrices_read++;
      r   = 0;
      c   = 0;
      up  = 1'b1;
      fin = 1'b0;
      while (!fin) begin
         fin         = (r == nr - 1) && (c == nc - 1);
         entry.value = element_mem[r * nc + c];
         entry.row   = r[ROW_WIDTH-1:0];
         entry.col   = c[COL_WIDTH-1:0];
         entry.last  = fin;
         walk_order.insert(walk_order.size(), entry);
         if (!fin) begin
            // Up-right walk turns at the top or right edge; down-left at the left or bottom.
            if (up) begin
               if (r == 0 && c < nc - 1) begin
                  c++;
                  up = 1'b0;
               end else if (c == nc - 1) begin
                  r++;
                  up = 1'b0;
               end else begin
                  r--;
                  c++;
               end
            end else begin
               if (c == 0 && r < nr - 1) begin
                  r++;
                  up = 1'b1;
               end else if (r == nr - 1) begin
                  c++;
                  up = 1'b1;
               end else begin
                  r++;
                  c--;
               end
            end
         end
      end
   endfunction

   // Moves a finished walk into the readout queue.
   function automatic void commit_walk();
      while (walk_order.size() != 0)
         readout_queue.insert(readout_queue.size(), walk_order.pop_front());
   endfunction

   function automatic void check_field(input string field, input logic [DATA_WIDTH-1:0] want,
                                       input logic [DATA_WIDTH-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, field, want, got);
      end
   endfunction

   function automatic void set_idling(input idle_mode_type mode);
      sender_gap_pct     = (mode == IDLE_SENDER) ? 61 : (mode == IDLE_BOTH) ? 8 : 0;
      receiver_stall_pct = (mode == IDLE_RECEIVER) ? 61 : (mode == IDLE_BOTH) ? 8 : 0;
   endfunction

   function automatic logic [DIM_WIDTH-1:0] pick_dim();
      if ($urandom_range(0, 3) == 0) return DIM_WIDTH'($urandom_range(0, 15));
      return DIM_WIDTH'($urandom_range(1, 8));
   endfunction

   function automatic logic [DATA_WIDTH-1:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Offers one element, with random gaps, and returns at the edge that takes it.
   task automatic send_element(input logic [DATA_WIDTH-1:0] value);
      while ($urandom_range(0, 99) < sender_gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
      load_element(value);
   endtask

   // Waits until every owed result has come and the block has gone quiet.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (readout_queue.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes both size registers; only called while the block is idle.
   task automatic write_dims(input logic [DIM_WIDTH-1:0] rows, input logic [DIM_WIDTH-1:0] cols);
      csr_valid <= 1'b1;
      csr_index <= REG_ROWS;
      csr_wdata <= rows;
      do @(posedge clock); while (!csr_ready);
      cfg_rows  = rows;
      csr_index <= REG_COLS;
      csr_wdata <= cols;
      do @(posedge clock); while (!csr_ready);
      cfg_cols  = cols;
      csr_valid <= 1'b0;
      dim_settings++;
   endtask

   // Result side: checks each accepted item and drives ready with stalls and the long hold-off.
   always @(posedge clock) begin : rsp_sink
      readout_type got;
      readout_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value = rsp_tdata[DATA_WIDTH-1:0];
         got.row   = rsp_tdata[DATA_WIDTH +: ROW_WIDTH];
         got.col   = rsp_tdata[DATA_WIDTH + ROW_WIDTH +: COL_WIDTH];
         got.last  = rsp_tlast;
         if (readout_queue.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result: value %0h row %0d col %0d last %0b",
                     $time, got.value, got.row, got.col, got.last);
         end else begin
            want = readout_queue.pop_front();
            results_checked++;
            check_field("out_value", want.value, got.value);
            check_field("out_row", 32'(want.row), 32'(got.row));
            check_field("out_col", 32'(want.col), 32'(got.col));
            check_field("out_last", 32'(want.last), 32'(got.last));
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_seen != hold_off_reqs) begin
         hold_off_seen = hold_off_reqs;
         hold_left     = HOLD_OFF_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
      end
   end

   // Directed table, random phases, then the verdict.
   initial begin : stimulus
      int             phase;
      int             nr;
      int             nc;
      int             matrices;
      int             remaining;
      logic [DIM_WIDTH-1:0] rows;
      logic [DIM_WIDTH-1:0] cols;
      directed_step_type step;

      plan = '{
         // Single element, extreme values.
         '{STEP_SET_DIMS, 4'd1, 4'd1, 32'h0, '0},
         '{STEP_LOAD_TYPED, 4'd0, 4'd0, 32'h7FFF_FFFF, '{32'h7FFF_FFFF, 3'd0, 3'd0, 1'b1}},
         '{STEP_LOAD_TYPED, 4'd0, 4'd0, 32'h8000_0000, '{32'h8000_0000, 3'd0, 3'd0, 1'b1}},
         // Zero sizes act as a single element.
         '{STEP_SET_DIMS, 4'd0, 4'd0, 32'h0, '0},
         '{STEP_LOAD_TYPED, 4'd0, 4'd0, 32'hFFFF_FFFF, '{32'hFFFF_FFFF, 3'd0, 3'd0, 1'b1}},
         '{STEP_LOAD_TYPED, 4'd0, 4'd0, 32'h0000_0000, '{32'h0000_0000, 3'd0, 3'd0, 1'b1}},
         // Two by two: one turn at each edge.
         '{STEP_SET_DIMS, 4'd2, 4'd2, 32'h0, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h0000_0011, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h0000_0022, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h0000_0033, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h0000_0044, '0},
         // Columns above the maximum saturate: one row of eight.
         '{STEP_SET_DIMS, 4'd1, 4'd15, 32'h0, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h5555_5555, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'hAAAA_AAAA, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h0000_0001, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h8000_0001, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h7FFF_FFFE, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'hFFFF_FFFF, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h1234_5678, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h8765_4321, '0},
         // Rows above the maximum saturate: one column of eight.
         '{STEP_SET_DIMS, 4'd15, 4'd1, 32'h0, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'hDEAD_BEEF, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h0F0F_0F0F, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'hF0F0_F0F0, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h0000_0000, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h7FFF_FFFF, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h8000_0000, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'h3C3C_C3C3, '0},
         '{STEP_LOAD, 4'd0, 4'd0, 32'hC3C3_3C3C, '0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling.
      set_idling(IDLE_NONE);
      for (int i = 0; i < PLAN_LEN; i++) begin
         step = plan[i];
         if (step.kind == STEP_SET_DIMS) begin
            wait_idle();
            write_dims(step.rows, step.cols);
         end else begin
            send_element(step.element);
            if (step.kind == STEP_LOAD_TYPED && walk_order.size() != 0) begin
               walk_order.delete();
               readout_queue.insert(readout_queue.size(), step.typed);
            end else begin
               commit_walk();
            end
         end
      end

      // Random phases: new sizes, then whole matrices of random elements.
      phase = 0;
      while (elements_loaded < RANDOM_ITEMS) begin
         wait_idle();
         set_idling(idle_mode_type'(phase % 4));
         if (phase == 0) begin
            rows = 4'd8;
            cols = 4'd8;
         end else begin
            rows = pick_dim();
            cols = pick_dim();
         end
         write_dims(rows, cols);
         // Long receiver hold-off once, so the block fills and stalls its input.
         if (phase == 2) hold_off_reqs++;
         nr        = span_of(rows, MAX_ROWS);
         nc        = span_of(cols, MAX_COLS);
         matrices  = $urandom_range(1, 4);
         remaining = RANDOM_ITEMS - elements_loaded;
         // Stop close to the planned number of items.
         if (matrices * nr * nc > remaining) matrices = (remaining + nr * nc - 1) / (nr * nc);
         for (int m = 0; m < matrices * nr * nc; m++) begin
            send_element(pick_element());
            commit_walk();
         end
         phase++;
      end

      wait_idle();
      $display("Loaded %0d elements as %0d matrices under %0d size settings, idling modes rotating.",
               elements_loaded, matrices_read, dim_settings);
      $display("Checked %0d zigzag results, including a %0d-cycle receiver hold-off.",
               results_checked, HOLD_OFF_CYCLES);
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Run limit.
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("%0t: run limit reached with %0d results outstanding", $time,
               readout_queue.size());
      $display("Test completed with failures");
      $finish;
   end

endmodule : tb_zigzag_reorder_buffer_top

FILE: zigzag_reorder_buffer_top.f
design/zrb_pkg.sv
design/zrb_ctrl.sv
design/zrb_datapath.sv
design/zigzag_reorder_buffer_top.sv
tb/tb_zigzag_reorder_buffer_top.sv
